@@ design/bed_pkg.sv @@
// bed_pkg: shared types and constants for the burn end detector
// no dependencies; imported by bed_lane, bed_merge and burn_end_detector

package bed_pkg;

    localparam int PHASE_W   = 2;
    localparam int COUNT_W   = 24;
    localparam int IMPULSE_W = 48;
    localparam int DELAY_W   = 8;
    localparam int RUN_W     = 12;

    localparam logic [PHASE_W-1:0] PH_BASE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_RUN  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_POST = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DONE = 2'd3;

    localparam logic [DELAY_W-1:0] DELAY_RESET     = 8'd5;
    localparam logic [RUN_W-1:0]   SAMPLES_PER_SEC = 12'd10;
    localparam logic [RUN_W-1:0]   RUN_MAX         = 12'hFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 24'hFFFFFF;

    localparam logic signed [IMPULSE_W-1:0] IMPULSE_MAX = {1'b0, {(IMPULSE_W-1){1'b1}}};
    localparam logic signed [IMPULSE_W-1:0] IMPULSE_MIN = {1'b1, {(IMPULSE_W-1){1'b0}}};

    typedef struct packed {
        logic clear;
        logic base_add;
        logic div_start;
        logic run_upd;
    } lane_ctrl_t;

endpackage

@@ design/bed_lane.sv @@
// bed_lane: one sensor channel - baseline sum, reciprocal divide to the average,
// at-baseline test and peak tracking; depends on bed_pkg

module bed_lane import bed_pkg::*; #(
    parameter int SAMPLE_BITS    = 24,
    parameter int BASELINE_COUNT = 50
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lane_ctrl_t                    ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          quiet,
    output logic signed [SAMPLE_BITS-1:0] peak_next,
    output logic                          busy
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(BASELINE_COUNT + 1);
    localparam int SHIFT = SUM_W + $clog2(BASELINE_COUNT);
    localparam int RCP_W = SUM_W + 1;
    localparam int MUL_W = SUM_W + RCP_W;
    localparam int DIF_W = SAMPLE_BITS + 1;
    localparam int PRD_W = SAMPLE_BITS + 6;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(BASELINE_COUNT) - 64'd1) / 64'(BASELINE_COUNT);
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_FULL);

    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] base_reg;
    logic signed [SAMPLE_BITS-1:0] peak_reg;
    logic                          div1_reg, div2_reg, div3_reg;
    logic [SUM_W-1:0]              mag_reg;
    logic                          neg_reg;
    logic [MUL_W-1:0]              prod_reg;
    logic [SAMPLE_BITS-1:0]        quot, base_fin;
    logic signed [DIF_W-1:0]       diff;
    logic [DIF_W-1:0]              abs_diff;
    logic [PRD_W-1:0]              scaled;

    always_comb begin
        sum_next = sum_reg;
        if (ctrl.clear) begin
            sum_next = '0;
        end else if (ctrl.base_add) begin
            sum_next = sum_reg + SUM_W'(sample);
        end
        peak_next = peak_reg;
        if (ctrl.clear) begin
            peak_next = '0;
        end else if (ctrl.run_upd && (sample > peak_reg)) begin
            peak_next = sample;
        end
        // divide by the baseline count: magnitude, reciprocal multiply, shift and sign
        quot     = prod_reg[SHIFT +: SAMPLE_BITS];
        base_fin = neg_reg ? (~quot + 1'b1) : quot;
    end

    // 20 * |x - base| < base, false for a non-positive base
    always_comb begin
        diff     = DIF_W'(sample) - DIF_W'(base_reg);
        abs_diff = diff[DIF_W-1] ? $unsigned(-diff) : $unsigned(diff);
        scaled   = PRD_W'(abs_diff) * PRD_W'(20);
        quiet    = !base_reg[SAMPLE_BITS-1] && (scaled < PRD_W'($unsigned(base_reg)));
    end

    assign busy = div1_reg || div2_reg || div3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            peak_reg <= '0;
            base_reg <= '0;
            div1_reg <= 1'b0;
            div2_reg <= 1'b0;
            div3_reg <= 1'b0;
        end else begin
            sum_reg  <= sum_next;
            peak_reg <= peak_next;
            div1_reg <= ctrl.div_start;
            div2_reg <= div1_reg;
            div3_reg <= div2_reg;
            if (ctrl.clear) begin
                base_reg <= '0;
            end else if (div3_reg) begin
                base_reg <= $signed(base_fin);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div1_reg) begin
            mag_reg <= sum_reg[SUM_W-1] ? $unsigned(-sum_reg) : $unsigned(sum_reg);
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (div2_reg) begin
            prod_reg <= MUL_W'(mag_reg) * MUL_W'(RECIP);
        end
    end

endmodule

@@ design/bed_merge.sv @@
// bed_merge: phase sequencer, sample count, impulse sum and the merge of the
// two lanes' at-baseline flags; depends on bed_pkg

module bed_merge import bed_pkg::*; #(
    parameter int SAMPLE_BITS    = 24,
    parameter int BASELINE_COUNT = 50
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [DELAY_W-1:0]            cfg_wr_data,
    input  logic                          accept,
    input  logic                          command,
    input  logic signed [SAMPLE_BITS-1:0] thrust,
    input  logic                          quiet_thrust,
    input  logic                          quiet_pressure,
    output lane_ctrl_t                    ctrl,
    output logic [PHASE_W-1:0]            phase_next,
    output logic [COUNT_W-1:0]            count_next,
    output logic signed [IMPULSE_W-1:0]   impulse_next,
    output logic                          done
);

    logic [DELAY_W-1:0]          delay_reg;
    logic [PHASE_W-1:0]          phase_reg;
    logic [COUNT_W-1:0]          count_reg, count_inc;
    logic signed [IMPULSE_W-1:0] impulse_reg, impulse_sat;
    logic signed [IMPULSE_W:0]   impulse_wide;
    logic [RUN_W-1:0]            quiet_reg, quiet_next, quiet_inc;
    logic [RUN_W-1:0]            post_reg, post_next, post_inc;
    logic [RUN_W-1:0]            confirm;

    always_comb begin
        confirm      = RUN_W'(delay_reg) * SAMPLES_PER_SEC;
        count_inc    = (count_reg < COUNT_MAX) ? count_reg + 1'b1 : count_reg;
        quiet_inc    = (quiet_reg < RUN_MAX) ? quiet_reg + 1'b1 : quiet_reg;
        post_inc     = (post_reg < RUN_MAX) ? post_reg + 1'b1 : post_reg;
        impulse_wide = (IMPULSE_W+1)'(impulse_reg) + (IMPULSE_W+1)'(thrust);
        if (impulse_wide[IMPULSE_W] != impulse_wide[IMPULSE_W-1]) begin
            impulse_sat = impulse_wide[IMPULSE_W] ? IMPULSE_MIN : IMPULSE_MAX;
        end else begin
            impulse_sat = impulse_wide[IMPULSE_W-1:0];
        end
    end

    always_comb begin
        ctrl         = '0;
        phase_next   = phase_reg;
        count_next   = count_reg;
        impulse_next = impulse_reg;
        quiet_next   = quiet_reg;
        post_next    = post_reg;
        done         = 1'b0;
        if (accept && command) begin
            ctrl.clear   = 1'b1;
            phase_next   = PH_BASE;
            count_next   = '0;
            impulse_next = '0;
            quiet_next   = '0;
            post_next    = '0;
        end else if (accept && (phase_reg != PH_DONE)) begin
            count_next = count_inc;
            unique case (phase_reg)
                PH_BASE: begin
                    ctrl.base_add = 1'b1;
                    if (count_inc >= COUNT_W'(BASELINE_COUNT)) begin
                        ctrl.div_start = 1'b1;
                        phase_next     = PH_RUN;
                    end
                end
                PH_RUN: begin
                    ctrl.run_upd = 1'b1;
                    impulse_next = impulse_sat;
                    if (quiet_thrust && quiet_pressure) begin
                        quiet_next = quiet_inc;
                        if (quiet_inc >= confirm) begin
                            post_next  = '0;
                            phase_next = PH_POST;
                            if (confirm == '0) begin
                                phase_next = PH_DONE;
                                done       = 1'b1;
                            end
                        end
                    end else begin
                        quiet_next = '0;
                    end
                end
                default: begin
                    ctrl.run_upd = 1'b1;
                    impulse_next = impulse_sat;
                    post_next    = post_inc;
                    if (post_inc >= confirm) begin
                        phase_next = PH_DONE;
                        done       = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg   <= DELAY_RESET;
            phase_reg   <= PH_BASE;
            count_reg   <= '0;
            impulse_reg <= '0;
            quiet_reg   <= '0;
            post_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                delay_reg <= cfg_wr_data;
            end
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            impulse_reg <= impulse_next;
            quiet_reg   <= quiet_next;
            post_reg    <= post_next;
        end
    end

endmodule

@@ design/burn_end_detector.sv @@
// burn_end_detector: top level - thrust and pressure lanes, merge stage and
// a two-entry result buffer; depends on bed_pkg, bed_lane, bed_merge
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    command, thrust_sample, pressure_sample
//   m_        out        m_valid/m_ready    phase, peaks, impulse, count, burn_done
//   cfg_      in         cfg_wr_en          end delay in seconds
//
// one request per cycle while s_ready is high; a result goes to the result register,
// or to the skid entry if that is full and m_ready is low; after the last baseline
// sample s_ready stays low while each lane divides its baseline sum by BASELINE_COUNT
// with a reciprocal multiply in three register stages (magnitude, product, shift and sign)
// a result register plus a skid entry keep s_ready independent of m_ready
// aresetn is synchronous, active low; the end delay resets to 5 seconds

module burn_end_detector import bed_pkg::*; #(
    parameter int SAMPLE_BITS    = 24,
    parameter int BASELINE_COUNT = 50
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [DELAY_W-1:0]            cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic signed [SAMPLE_BITS-1:0] s_thrust_sample,
    input  logic signed [SAMPLE_BITS-1:0] s_pressure_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [PHASE_W-1:0]            m_phase,
    output logic signed [SAMPLE_BITS-1:0] m_peak_thrust,
    output logic signed [SAMPLE_BITS-1:0] m_peak_pressure,
    output logic signed [IMPULSE_W-1:0]   m_impulse_total,
    output logic [COUNT_W-1:0]            m_samples_seen,
    output logic                          m_burn_done
);

    lane_ctrl_t                    ctrl;
    logic                          accept;
    logic                          quiet_thr, quiet_prs, busy_thr, busy_prs;
    logic signed [SAMPLE_BITS-1:0] peak_thr, peak_prs;
    logic [PHASE_W-1:0]            phase_next;
    logic [COUNT_W-1:0]            count_next;
    logic signed [IMPULSE_W-1:0]   impulse_next;
    logic                          done;

    logic                          out_valid_reg, skid_valid_reg;
    logic [PHASE_W-1:0]            out_phase_reg, skid_phase_reg;
    logic signed [SAMPLE_BITS-1:0] out_pthr_reg, skid_pthr_reg;
    logic signed [SAMPLE_BITS-1:0] out_pprs_reg, skid_pprs_reg;
    logic signed [IMPULSE_W-1:0]   out_imp_reg, skid_imp_reg;
    logic [COUNT_W-1:0]            out_cnt_reg, skid_cnt_reg;
    logic                          out_done_reg, skid_done_reg;
    logic                          out_free;

    assign s_ready  = !skid_valid_reg && !busy_thr && !busy_prs;
    assign accept   = s_valid && s_ready;
    assign out_free = m_ready || !out_valid_reg;

    bed_lane #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .BASELINE_COUNT (BASELINE_COUNT)
    ) u_lane_thr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .sample    (s_thrust_sample),
        .quiet     (quiet_thr),
        .peak_next (peak_thr),
        .busy      (busy_thr)
    );

    bed_lane #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .BASELINE_COUNT (BASELINE_COUNT)
    ) u_lane_prs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .sample    (s_pressure_sample),
        .quiet     (quiet_prs),
        .peak_next (peak_prs),
        .busy      (busy_prs)
    );

    bed_merge #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .BASELINE_COUNT (BASELINE_COUNT)
    ) u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .accept         (accept),
        .command        (s_command),
        .thrust         (s_thrust_sample),
        .quiet_thrust   (quiet_thr),
        .quiet_pressure (quiet_prs),
        .ctrl           (ctrl),
        .phase_next     (phase_next),
        .count_next     (count_next),
        .impulse_next   (impulse_next),
        .done           (done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_phase_reg <= skid_phase_reg;
                out_pthr_reg  <= skid_pthr_reg;
                out_pprs_reg  <= skid_pprs_reg;
                out_imp_reg   <= skid_imp_reg;
                out_cnt_reg   <= skid_cnt_reg;
                out_done_reg  <= skid_done_reg;
            end else begin
                out_phase_reg <= phase_next;
                out_pthr_reg  <= peak_thr;
                out_pprs_reg  <= peak_prs;
                out_imp_reg   <= impulse_next;
                out_cnt_reg   <= count_next;
                out_done_reg  <= done;
            end
        end else if (accept) begin
            skid_phase_reg <= phase_next;
            skid_pthr_reg  <= peak_thr;
            skid_pprs_reg  <= peak_prs;
            skid_imp_reg   <= impulse_next;
            skid_cnt_reg   <= count_next;
            skid_done_reg  <= done;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_phase         = out_phase_reg;
    assign m_peak_thrust   = out_pthr_reg;
    assign m_peak_pressure = out_pprs_reg;
    assign m_impulse_total = out_imp_reg;
    assign m_samples_seen  = out_cnt_reg;
    assign m_burn_done     = out_done_reg;

    a_done_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_burn_done |-> m_phase == PH_DONE)
        else $error("burn_done without finished phase");

    a_lanes_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_thr == busy_prs)
        else $error("lane dividers out of step");

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty result register");

    a_baseline_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_phase == PH_BASE |->
            m_peak_thrust == '0 && m_peak_pressure == '0 && m_impulse_total == '0)
        else $error("peaks or impulse moved during baseline");

endmodule

@@ tb/sv/burn_end_detector_tb.sv @@
// burn_end_detector_tb: self-checking bench for the burn end detector, a table of
// directed requests, fixed burn scenarios and random burns checked against a predictor
// depends on bed_pkg and burn_end_detector

module burn_end_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bed_pkg::*;

    localparam int SMP_W       = 24;
    localparam int BASE_N      = 50;
    localparam int IDLE_PCT    = 7;
    localparam int DRAIN       = 40;
    localparam int STALL_LIMIT = 2000;
    localparam int N_ITEMS     = 1600;
    localparam int N_ROWS      = 11;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_START  = 1'b1;

    localparam longint IMP_HI = longint'(IMPULSE_MAX);
    localparam longint IMP_LO = longint'(IMPULSE_MIN);

    typedef struct packed {
        logic [PHASE_W-1:0]          phase;
        logic signed [SMP_W-1:0]     peak_thrust;
        logic signed [SMP_W-1:0]     peak_pressure;
        logic signed [IMPULSE_W-1:0] impulse_total;
        logic [COUNT_W-1:0]          samples_seen;
        logic                        burn_done;
    } burn_status_t;

    typedef struct packed {
        logic                    cmd;
        logic signed [SMP_W-1:0] thrust;
        logic signed [SMP_W-1:0] pressure;
        logic                    typed;
        burn_status_t            want;
    } stim_row_t;

    function automatic burn_status_t early(input int n);
        burn_status_t r;
        r = '0;
        r.phase = PH_BASE;
        r.samples_seen = COUNT_W'(n);
        return r;
    endfunction

    localparam stim_row_t DIR_ROWS [N_ROWS] = '{
        '{CMD_START,  24'sh7FFFFF, 24'sh800000, 1'b1, early(0)},
        '{CMD_SAMPLE, 24'sh7FFFFF, 24'sh800000, 1'b1, early(1)},
        '{CMD_SAMPLE, 24'sh800000, 24'sh7FFFFF, 1'b1, early(2)},
        '{CMD_SAMPLE, 24'sh000000, 24'sh000000, 1'b1, early(3)},
        '{CMD_SAMPLE, 24'shFFFFFF, 24'shFFFFFF, 1'b1, early(4)},
        '{CMD_START,  24'shFFFFFF, 24'shFFFFFF, 1'b1, early(0)},
        '{CMD_START,  24'sh000000, 24'sh000000, 1'b1, early(0)},
        '{CMD_SAMPLE, 24'sh000001, 24'sh555555, 1'b0, '0},
        '{CMD_SAMPLE, 24'shAAAAAA, 24'sh000001, 1'b0, '0},
        '{CMD_SAMPLE, 24'sh123456, 24'shEDCBA9, 1'b0, '0},
        '{CMD_START,  24'sh555555, 24'shAAAAAA, 1'b1, early(0)}
    };

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [DELAY_W-1:0]      cfg_wr_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_command = 1'b0;
    logic signed [SMP_W-1:0] s_thrust_sample = '0;
    logic signed [SMP_W-1:0] s_pressure_sample = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [PHASE_W-1:0]          m_phase;
    logic signed [SMP_W-1:0]     m_peak_thrust;
    logic signed [SMP_W-1:0]     m_peak_pressure;
    logic signed [IMPULSE_W-1:0] m_impulse_total;
    logic [COUNT_W-1:0]          m_samples_seen;
    logic                        m_burn_done;

    burn_end_detector #(
        .SAMPLE_BITS   (SMP_W),
        .BASELINE_COUNT(BASE_N)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_thrust_sample  (s_thrust_sample),
        .s_pressure_sample(s_pressure_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_phase          (m_phase),
        .m_peak_thrust    (m_peak_thrust),
        .m_peak_pressure  (m_peak_pressure),
        .m_impulse_total  (m_impulse_total),
        .m_samples_seen   (m_samples_seen),
        .m_burn_done      (m_burn_done)
    );

    always #10 aclk = ~aclk;

    // predictor state
    logic [DELAY_W-1:0] mdl_delay;
    logic [PHASE_W-1:0] mdl_phase;
    logic [COUNT_W-1:0] mdl_count;
    longint             mdl_tbase;
    longint             mdl_pbase;
    longint             mdl_tpeak;
    longint             mdl_ppeak;
    longint             mdl_impulse;
    int                 mdl_quiet;
    int                 mdl_post;

    burn_status_t burn_status_q [$];
    burn_status_t want_status;
    burn_status_t got_status;

    bit idle_on = 1'b1;
    int n_sent = 0;
    int n_checked = 0;
    int n_burns = 0;
    int n_cfg = 0;
    int n_errors = 0;
    int stall = 0;

    function automatic void clear_model();
        mdl_phase = PH_BASE;
        mdl_count = '0;
        mdl_tbase = 0;
        mdl_pbase = 0;
        mdl_tpeak = 0;
        mdl_ppeak = 0;
        mdl_impulse = 0;
        mdl_quiet = 0;
        mdl_post = 0;
    endfunction

    function automatic void add_sample(input longint t, input longint p);
        longint s;
        s = mdl_impulse + t;
        if (s > IMP_HI) s = IMP_HI;
        if (s < IMP_LO) s = IMP_LO;
        mdl_impulse = s;
        if (t > mdl_tpeak) mdl_tpeak = t;
        if (p > mdl_ppeak) mdl_ppeak = p;
    endfunction

    function automatic bit at_base(input longint x, input longint b);
        longint d;
        d = x - b;
        if (d < 0) d = -d;
        return d * 20 < b;
    endfunction

    function automatic burn_status_t predict_burn_status(input logic cmd,
            input logic signed [SMP_W-1:0] thr, input logic signed [SMP_W-1:0] prs);
        burn_status_t r;
        int conf;
        longint t;
        longint p;
        logic done;
        conf = int'(mdl_delay) * 10;
        t = longint'(thr);
        p = longint'(prs);
        done = 1'b0;
        if (cmd == CMD_START) begin
            clear_model();
        end else if (mdl_phase != PH_DONE) begin
            if (mdl_count != COUNT_MAX) mdl_count = mdl_count + 1'b1;
            case (mdl_phase)
                PH_BASE: begin
                    mdl_tbase += t;
                    mdl_pbase += p;
                    if (mdl_count >= COUNT_W'(BASE_N)) begin
                        mdl_tbase = mdl_tbase / BASE_N;
                        mdl_pbase = mdl_pbase / BASE_N;
                        mdl_phase = PH_RUN;
                    end
                end
                PH_RUN: begin
                    add_sample(t, p);
                    if (at_base(t, mdl_tbase) && at_base(p, mdl_pbase)) begin
                        if (mdl_quiet < int'(RUN_MAX)) mdl_quiet++;
                        if (mdl_quiet >= conf) begin
                            mdl_post = 0;
                            mdl_phase = PH_POST;
                            if (conf == 0) begin
                                mdl_phase = PH_DONE;
                                done = 1'b1;
                            end
                        end
                    end else begin
                        mdl_quiet = 0;
                    end
                end
                default: begin
                    add_sample(t, p);
                    if (mdl_post < int'(RUN_MAX)) mdl_post++;
                    if (mdl_post >= conf) begin
                        mdl_phase = PH_DONE;
                        done = 1'b1;
                    end
                end
            endcase
        end
        r.phase = mdl_phase;
        r.peak_thrust = mdl_tpeak[SMP_W-1:0];
        r.peak_pressure = mdl_ppeak[SMP_W-1:0];
        r.impulse_total = mdl_impulse[IMPULSE_W-1:0];
        r.samples_seen = mdl_count;
        r.burn_done = done;
        return r;
    endfunction

    function automatic logic signed [SMP_W-1:0] rand_sample();
        logic [31:0] r;
        r = $urandom();
        return r[SMP_W-1:0];
    endfunction

    function automatic logic signed [SMP_W-1:0] near_val(input longint base, input int div);
        longint span;
        span = (base < 0 ? -base : base) / div + 1;
        return SMP_W'(base + longint'($urandom_range(0, 32'(2 * span))) - span);
    endfunction

    task automatic send_req(input logic cmd, input logic signed [SMP_W-1:0] thr,
            input logic signed [SMP_W-1:0] prs);
        if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (idle_on && $urandom_range(0, 99) < IDLE_PCT);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_thrust_sample <= thr;
        s_pressure_sample <= prs;
        do @(posedge aclk); while (!s_ready);
        burn_status_q.push_back(predict_burn_status(cmd, thr, prs));
        n_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (burn_status_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_end_delay(input logic [DELAY_W-1:0] v);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mdl_delay = v;
        n_cfg++;
    endtask

    task automatic send_near(input longint bt, input longint bp, input int n, input int div);
        repeat (n) send_req(CMD_SAMPLE, near_val(bt, div), near_val(bp, div));
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_req(CMD_SAMPLE, rand_sample(), rand_sample());
    endtask

    // one channel stays near its baseline, the other does not
    task automatic send_break(input longint bt, input longint bp);
        if ($urandom_range(0, 1) == 0) begin
            send_req(CMD_SAMPLE, near_val(bt, 40), rand_sample());
        end else begin
            send_req(CMD_SAMPLE, rand_sample(), near_val(bp, 40));
        end
    endtask

    task automatic burn_test();
        int pick;
        int conf;
        longint bt;
        longint bp;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            write_end_delay(DELAY_W'($urandom_range(0, 3)));
        end else if (pick < 9) begin
            write_end_delay(DELAY_W'($urandom_range(4, 10)));
        end
        conf = int'(mdl_delay) * 10;
        bt = longint'($urandom_range(1000, 8000000));
        bp = longint'($urandom_range(1000, 8000000));
        send_req(CMD_START, rand_sample(), rand_sample());
        send_near(bt, bp, BASE_N, 160);
        send_noise($urandom_range(1, 12));
        if (conf > 1) begin
            repeat ($urandom_range(0, 3)) begin
                send_near(bt, bp, $urandom_range(0, conf - 1), 40);
                send_break(bt, bp);
            end
        end
        send_near(bt, bp, (conf > 0) ? conf : 1, 40);
        send_noise(conf);
        send_noise($urandom_range(1, 3));
    endtask

    task automatic noise_test();
        send_req(CMD_START, rand_sample(), rand_sample());
        repeat ($urandom_range(10, 80)) begin
            if ($urandom_range(0, 29) == 0) begin
                send_req(CMD_START, rand_sample(), rand_sample());
            end else begin
                send_req(CMD_SAMPLE, rand_sample(), rand_sample());
            end
        end
    endtask

    initial begin : stimulus
        longint bt;
        longint bp;
        int k;
        mdl_delay = DELAY_RESET;
        clear_model();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            send_req(DIR_ROWS[i].cmd, DIR_ROWS[i].thrust, DIR_ROWS[i].pressure);
            if (DIR_ROWS[i].typed) burn_status_q[burn_status_q.size() - 1] = DIR_ROWS[i].want;
        end

        // longest window, then a lower delay while a quiet run is under way
        bt = longint'($urandom_range(1000, 8000000));
        bp = longint'($urandom_range(1000, 8000000));
        write_end_delay(8'd255);
        send_req(CMD_START, rand_sample(), rand_sample());
        send_near(bt, bp, BASE_N, 160);
        send_noise(5);
        send_near(bt, bp, 60, 40);
        write_end_delay(8'd1);
        send_near(bt, bp, 1, 40);
        send_noise(12);

        // zero delay ends the burn on the first quiet sample
        write_end_delay(8'd0);
        send_req(CMD_START, rand_sample(), rand_sample());
        send_near(bt, bp, BASE_N, 160);
        send_noise(4);
        send_break(bt, bp);
        send_near(bt, bp, 1, 40);
        send_noise(3);

        // delay lowered below the post-burn count
        write_end_delay(8'd4);
        send_req(CMD_START, rand_sample(), rand_sample());
        send_near(bt, bp, BASE_N, 160);
        send_noise(3);
        send_near(bt, bp, 40, 40);
        send_noise(25);
        write_end_delay(8'd2);
        send_noise(3);

        // zero and negative baselines never confirm
        write_end_delay(8'd1);
        send_req(CMD_START, rand_sample(), rand_sample());
        send_near(0, -5000, BASE_N, 160);
        send_near(0, -5000, 30, 40);
        send_req(CMD_START, rand_sample(), rand_sample());
        send_near(-200000, -3000000, BASE_N, 160);
        send_near(-200000, -3000000, 15, 40);
        send_noise(5);

        k = 0;
        while (n_sent < N_ITEMS) begin
            idle_on = !(k == 3 || k == 4);
            if ($urandom_range(0, 4) == 0) begin
                noise_test();
            end else begin
                burn_test();
            end
            k++;
        end
        idle_on = 1'b1;
        wait_idle();

        $display("%0d requests sent, %0d results checked, %0d burn ends flagged",
                 n_sent, n_checked, n_burns);
        $display("%0d end delay settings applied, %0d mismatches", n_cfg, n_errors);
        if (n_errors == 0 && burn_status_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_status.phase = m_phase;
            got_status.peak_thrust = m_peak_thrust;
            got_status.peak_pressure = m_peak_pressure;
            got_status.impulse_total = m_impulse_total;
            got_status.samples_seen = m_samples_seen;
            got_status.burn_done = m_burn_done;
            if (m_burn_done) n_burns++;
            if (burn_status_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("result %0d arrived with nothing expected", n_checked);
            end else begin
                want_status = burn_status_q.pop_front();
                if (got_status.phase !== want_status.phase
                        || got_status.peak_thrust !== want_status.peak_thrust
                        || got_status.peak_pressure !== want_status.peak_pressure
                        || got_status.impulse_total !== want_status.impulse_total
                        || got_status.samples_seen !== want_status.samples_seen
                        || got_status.burn_done !== want_status.burn_done) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("result %0d mismatch (expected / actual):", n_checked);
                        $display("  phase %0d / %0d, peak thrust %0d / %0d, peak pressure %0d / %0d",
                                 want_status.phase, got_status.phase,
                                 want_status.peak_thrust, got_status.peak_thrust,
                                 want_status.peak_pressure, got_status.peak_pressure);
                        $display("  impulse %0d / %0d, samples %0d / %0d, done %0b / %0b",
                                 want_status.impulse_total, got_status.impulse_total,
                                 want_status.samples_seen, got_status.samples_seen,
                                 want_status.burn_done, got_status.burn_done);
                    end
                end
            end
            n_checked++;
        end
        m_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall <= 0;
        end else begin
            stall <= stall + 1;
        end
        if (stall >= STALL_LIMIT) begin
            $display("no request moved for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

endmodule
